### design/grid_pair_channel_scoring_unit_macros.svh
// Assertion macros shared by the grid pair channel scoring unit files.
`ifndef GRID_PAIR_CHANNEL_SCORING_UNIT_MACROS_SVH
`define GRID_PAIR_CHANNEL_SCORING_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GPCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define GPCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gpcs_pkg.sv
// Types and widths shared by the grid pair channel scoring unit.
package gpcs_pkg;

  localparam int WEIGHT_W   = 16;
  localparam int COLOR_W    = 8;
  localparam int CNT_W      = 13;
  localparam int CG_PROD_W  = 2 * COLOR_W;
  localparam int WT_PROD_W  = COLOR_W + WEIGHT_W;
  localparam int CG_ACC_W   = 29;
  localparam int CG_OUT_W   = 28;
  localparam int WT_ACC_W   = 37;
  localparam int WT_OUT_W   = 36;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USED_W = CNT_W + 2 * CG_OUT_W + 2 * WT_OUT_W;

  // One cell pair after the similarity products are formed.
  typedef struct packed {
    logic                 last;
    logic                 active;
    logic [CG_PROD_W-1:0] red_green;
    logic [CG_PROD_W-1:0] blue_green;
    logic [WT_PROD_W-1:0] blue_weight;
    logic [WT_PROD_W-1:0] red_weight;
  } prod_t;

  // One emitted set of clamped sums.
  typedef struct packed {
    logic [WT_OUT_W-1:0] red_weight_sum;
    logic [WT_OUT_W-1:0] blue_weight_sum;
    logic [CG_OUT_W-1:0] blue_green_sum;
    logic [CG_OUT_W-1:0] red_green_sum;
    logic [CNT_W-1:0]    overlap_count;
  } result_t;

endpackage

### design/gpcs_accum.sv
// Saturating accumulators for the five grid pair sums and their output clamp.
module gpcs_accum import gpcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    consume,
  input  prod_t   item,
  output result_t result
);

  logic [CNT_W-1:0]    overlap_acc;
  logic [CG_ACC_W-1:0] red_green_acc;
  logic [CG_ACC_W-1:0] blue_green_acc;
  logic [WT_ACC_W-1:0] blue_weight_acc;
  logic [WT_ACC_W-1:0] red_weight_acc;

  logic [CNT_W:0]       cnt_sum;
  logic [CG_ACC_W:0]    rg_sum;
  logic [CG_ACC_W:0]    bg_sum;
  logic [WT_ACC_W:0]    bw_sum;
  logic [WT_ACC_W:0]    rw_sum;
  logic [CNT_W-1:0]     overlap_acc_next;
  logic [CG_ACC_W-1:0]  red_green_acc_next;
  logic [CG_ACC_W-1:0]  blue_green_acc_next;
  logic [WT_ACC_W-1:0]  blue_weight_acc_next;
  logic [WT_ACC_W-1:0]  red_weight_acc_next;
  logic [CG_PROD_W-1:0] rg_add;
  logic [CG_PROD_W-1:0] bg_add;
  logic [WT_PROD_W-1:0] bw_add;
  logic [WT_PROD_W-1:0] rw_add;

  // Gate contributions of inactive cell pairs
  assign rg_add = item.active ? item.red_green   : '0;
  assign bg_add = item.active ? item.blue_green  : '0;
  assign bw_add = item.active ? item.blue_weight : '0;
  assign rw_add = item.active ? item.red_weight  : '0;

  // Add with one carry bit
  assign cnt_sum = {1'b0, overlap_acc} + {{CNT_W{1'b0}}, item.active};
  assign rg_sum  = {1'b0, red_green_acc}  + {{(CG_ACC_W+1-CG_PROD_W){1'b0}}, rg_add};
  assign bg_sum  = {1'b0, blue_green_acc} + {{(CG_ACC_W+1-CG_PROD_W){1'b0}}, bg_add};
  assign bw_sum  = {1'b0, blue_weight_acc} + {{(WT_ACC_W+1-WT_PROD_W){1'b0}}, bw_add};
  assign rw_sum  = {1'b0, red_weight_acc}  + {{(WT_ACC_W+1-WT_PROD_W){1'b0}}, rw_add};

  // Saturate at the all-ones value of each accumulator
  assign overlap_acc_next     = cnt_sum[CNT_W]   ? '1 : cnt_sum[CNT_W-1:0];
  assign red_green_acc_next   = rg_sum[CG_ACC_W] ? '1 : rg_sum[CG_ACC_W-1:0];
  assign blue_green_acc_next  = bg_sum[CG_ACC_W] ? '1 : bg_sum[CG_ACC_W-1:0];
  assign blue_weight_acc_next = bw_sum[WT_ACC_W] ? '1 : bw_sum[WT_ACC_W-1:0];
  assign red_weight_acc_next  = rw_sum[WT_ACC_W] ? '1 : rw_sum[WT_ACC_W-1:0];

  // Clamp the updated sums to the output field widths
  always_comb begin
    result.overlap_count   = overlap_acc_next;
    result.red_green_sum   = red_green_acc_next[CG_ACC_W-1]
                             ? '1 : red_green_acc_next[CG_OUT_W-1:0];
    result.blue_green_sum  = blue_green_acc_next[CG_ACC_W-1]
                             ? '1 : blue_green_acc_next[CG_OUT_W-1:0];
    result.blue_weight_sum = blue_weight_acc_next[WT_ACC_W-1]
                             ? '1 : blue_weight_acc_next[WT_OUT_W-1:0];
    result.red_weight_sum  = red_weight_acc_next[WT_ACC_W-1]
                             ? '1 : red_weight_acc_next[WT_OUT_W-1:0];
  end

  // Advance the sums, clear them after the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_acc     <= '0;
      red_green_acc   <= '0;
      blue_green_acc  <= '0;
      blue_weight_acc <= '0;
      red_weight_acc  <= '0;
    end else if (consume) begin
      if (item.last) begin
        overlap_acc     <= '0;
        red_green_acc   <= '0;
        blue_green_acc  <= '0;
        blue_weight_acc <= '0;
        red_weight_acc  <= '0;
      end else begin
        overlap_acc     <= overlap_acc_next;
        red_green_acc   <= red_green_acc_next;
        blue_green_acc  <= blue_green_acc_next;
        blue_weight_acc <= blue_weight_acc_next;
        red_weight_acc  <= red_weight_acc_next;
      end
    end
  end

  `include "grid_pair_channel_scoring_unit_macros.svh"

  `GPCS_ASSERT_NEXT(a_clear_after_last, consume && item.last, overlap_acc == '0 && red_green_acc == '0 && blue_green_acc == '0 && blue_weight_acc == '0 && red_weight_acc == '0, "sums not cleared after last cell")
  `GPCS_ASSERT_SAME(a_empty_sums_zero, overlap_acc == '0, red_green_acc == '0 && blue_green_acc == '0 && blue_weight_acc == '0 && red_weight_acc == '0, "sums nonzero with no overlap")
  `GPCS_ASSERT_NEXT(a_count_grows, consume && !item.last && item.active, overlap_acc != '0, "active cell not counted")

endmodule

### design/grid_pair_channel_scoring_unit.sv
// Top level of the grid pair channel scoring unit: handshake, similarity stage, result register.
// The unit takes one cell pair per clock and folds it into five saturating sums; on the
// transaction that carries tlast it emits one result and restarts the sums. A cell pair
// passes an input register, a product register (absolute differences, channel similarities,
// minimum activation and four small multiplies) and the accumulators; a last cell's result then
// is held in the output register for the master side. Throughput is one cell pair per cycle;
// only a last cell waits when an earlier result is still held in the output register, and
// the cells ahead of it keep flowing until then.
module grid_pair_channel_scoring_unit import gpcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // a_weight[15:0], b_weight[31:16], a_red[39:32], b_red[47:40],
  // a_green[55:48], b_green[63:56], a_blue[71:64], b_blue[79:72]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,   // last_cell
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // overlap_count[12:0], red_green_sum[40:13], blue_green_sum[68:41],
  // blue_weight_sum[104:69], red_weight_sum[140:105], zeros[143:141]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                i_valid;
  logic                i_last;
  logic [WEIGHT_W-1:0] a_weight;
  logic [WEIGHT_W-1:0] b_weight;
  logic [COLOR_W-1:0]  a_red;
  logic [COLOR_W-1:0]  b_red;
  logic [COLOR_W-1:0]  a_green;
  logic [COLOR_W-1:0]  b_green;
  logic [COLOR_W-1:0]  a_blue;
  logic [COLOR_W-1:0]  b_blue;

  logic    p_valid;
  prod_t   prod;
  prod_t   prod_next;
  logic    out_valid;
  result_t out_res;
  result_t acc_res;

  logic                out_free;
  logic                p_consume;
  logic                p_load_ok;
  logic                i_consume;
  logic                s_accept;
  logic [COLOR_W-1:0]  red_diff;
  logic [COLOR_W-1:0]  green_diff;
  logic [COLOR_W-1:0]  blue_diff;
  logic [COLOR_W-1:0]  red_sim;
  logic [COLOR_W-1:0]  green_sim;
  logic [COLOR_W-1:0]  blue_sim;
  logic [WEIGHT_W-1:0] min_weight;

  // Stage handshakes: only a last cell needs a free output slot
  assign out_free  = !out_valid || m_tready;
  assign p_consume = p_valid && (!prod.last || out_free);
  assign p_load_ok = !p_valid || p_consume;
  assign i_consume = i_valid && p_load_ok;
  assign s_tready  = !i_valid || p_load_ok;
  assign s_accept  = s_tvalid && s_tready;

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (s_accept) begin
      i_valid <= 1'b1;
    end else if (i_consume) begin
      i_valid <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_weight <= s_tdata[15:0];
      b_weight <= s_tdata[31:16];
      a_red    <= s_tdata[39:32];
      b_red    <= s_tdata[47:40];
      a_green  <= s_tdata[55:48];
      b_green  <= s_tdata[63:56];
      a_blue   <= s_tdata[71:64];
      b_blue   <= s_tdata[79:72];
      i_last   <= s_tlast;
    end
  end

  // Channel similarity is 255 - |a - b|, the bitwise inverse of the 8-bit difference
  assign red_diff   = (a_red > b_red)     ? a_red - b_red     : b_red - a_red;
  assign green_diff = (a_green > b_green) ? a_green - b_green : b_green - a_green;
  assign blue_diff  = (a_blue > b_blue)   ? a_blue - b_blue   : b_blue - a_blue;
  assign red_sim    = ~red_diff;
  assign green_sim  = ~green_diff;
  assign blue_sim   = ~blue_diff;
  assign min_weight = (a_weight < b_weight) ? a_weight : b_weight;

  // Form the four products of one cell pair
  always_comb begin
    prod_next.last        = i_last;
    prod_next.active      = (a_weight != '0) && (b_weight != '0);
    prod_next.red_green   = {{COLOR_W{1'b0}}, red_sim} * {{COLOR_W{1'b0}}, green_sim};
    prod_next.blue_green  = {{COLOR_W{1'b0}}, blue_sim} * {{COLOR_W{1'b0}}, green_sim};
    prod_next.blue_weight = {{WEIGHT_W{1'b0}}, blue_sim} * {{COLOR_W{1'b0}}, min_weight};
    prod_next.red_weight  = {{WEIGHT_W{1'b0}}, red_sim} * {{COLOR_W{1'b0}}, min_weight};
  end

  // Product register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (i_consume) begin
      p_valid <= 1'b1;
    end else if (p_consume) begin
      p_valid <= 1'b0;
    end
  end

  // Product register payload
  always_ff @(posedge clk) begin
    if (i_consume) begin
      prod <= prod_next;
    end
  end

  gpcs_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .consume (p_consume),
    .item    (prod),
    .result  (acc_res)
  );

  // Output register valid: load on the last cell, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_consume && prod.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (p_consume && prod.last) begin
      out_res <= acc_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_res};

  `include "grid_pair_channel_scoring_unit_macros.svh"

  `GPCS_ASSERT_SAME(a_ready_only_when_full, !s_tready, i_valid && p_valid, "input stalled with room in the pipe")
  `GPCS_ASSERT_NEXT(a_last_held, p_valid && prod.last && !out_free, p_valid && prod.last, "last cell lost while output busy")
  `GPCS_ASSERT_SAME(a_result_from_last, out_valid && !$past(out_valid), $past(p_valid && prod.last), "result raised without a last cell")

endmodule
